// ===== rtl/core/wsmf_pkg.sv =====
package wsmf_pkg;

  // field and storage widths
  localparam int CELL_W   = 16;
  localparam int SUM_W    = 18;
  localparam int WEIGHT_W = 8;
  localparam int DAY_W    = 3;
  localparam int SLOT_W   = 5;
  localparam int CNT_W    = 8;

  // saturation limits
  localparam logic [CELL_W-1:0] CELL_MAX = 16'hFFFF;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 18'h3FFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;

  // operation selector carried on s_tuser
  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FIND  = 2'd1,
    MODE_FETCH = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD,
    ST_FIND,
    ST_DRAIN,
    ST_FETCH,
    ST_CLEAR,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/window_sum_minimum_finder.sv =====
// Weekly grid of slot weights with a sliding-window minimum search. Each
// transaction on the s side carries the operation on s_tuser and yields
// exactly one transaction on the m side. Add reads the cell, adds the weight
// with saturation and writes it back. Clear walks the grid and zeroes it.
// Find walks the grid once through a sliding sum, storing every window sum.
// Fetch scans the stored window sums from where the last fetch stopped, one
// entry per cycle. The grid memory port is what paces add, clear and find;
// the window memory port paces fetch. After reset the grid is zeroed by a
// pass over every cell, during which s_tready stays low. One operation is in
// flight at a time; a finished result waits in the output register while the
// next transaction is taken.
module window_sum_minimum_finder
  import wsmf_pkg::*;
#(
  parameter int DAYS   = 7,
  parameter int SLOTS  = 32,
  parameter int WINDOW = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // day[2:0], slot[7:3], weight[15:8]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // min_sum[17:0], match_count[25:18], found_day[28:26],
                                 // found_start_slot[33:29], found_end_slot[38:34]
  output logic [0:0]  m_tuser,   // valid_res[0]
  output logic        m_tlast    // last
);

  localparam int SB        = $clog2(SLOTS);
  localparam int GAW       = DAY_W + SB;
  localparam int STARTS    = (SLOTS >= WINDOW) ? (SLOTS - WINDOW + 1) : 0;
  localparam int STARTS_M1 = (STARTS > 0) ? (STARTS - 1) : 0;
  localparam int WIN_TOTAL = DAYS * STARTS;
  localparam int KW        = $clog2(WIN_TOTAL + 2);

  state_t state, state_next;

  // input decode
  mode_t             in_mode;
  logic [DAY_W-1:0]  in_day;
  logic [SLOT_W-1:0] in_slot;
  logic [6:0]        in_slot7;
  logic [WEIGHT_W-1:0] in_weight;
  logic              in_ok;
  logic [GAW-1:0]    in_addr;
  logic              accept;

  // sweep counters shared by init, clear and find
  logic [DAY_W-1:0] fd;
  logic [SB-1:0]    fs;
  logic             sweep_last;

  // find pipeline
  logic          p1_valid;
  logic [SB-1:0] p1_slot;
  logic [6:0]    p1_slot7;
  logic          acc_valid;
  logic [SUM_W-1:0] acc_sum;
  logic [KW-1:0] k;
  logic [SUM_W-1:0] best;
  logic [KW-1:0] cnt;
  logic          drain_done;

  // results of the last find and fetch position
  logic [SUM_W-1:0] minimum;
  logic [KW-1:0]    match_total;
  logic [KW-1:0]    delivered;
  logic [KW-1:0]    scan_idx;
  logic [DAY_W-1:0] scan_day;
  logic [SB-1:0]    scan_start;

  // fetch scan
  logic [KW-1:0]    ptr_idx;
  logic [DAY_W-1:0] ptr_day;
  logic [SB-1:0]    ptr_start;
  logic             pend_valid;
  logic [DAY_W-1:0] pend_day;
  logic [SB-1:0]    pend_start;
  logic             hit;
  logic             exhausted;

  // add operation
  logic             a_ok;
  logic [GAW-1:0]   a_addr;
  logic [WEIGHT_W-1:0] a_weight;
  logic [CELL_W:0]  add_sum;
  logic [CELL_W-1:0] add_sat;

  // pending result
  logic             r_valid;
  logic [DAY_W-1:0] r_day;
  logic [SB-1:0]    r_start;
  logic             r_last;
  logic             out_free;
  logic [6:0]       r_start7;
  logic [6:0]       r_end7;
  logic [15:0]      cnt_ext;
  logic [CNT_W-1:0] cnt_out;

  // memory ports
  logic              grid_rd_en;
  logic [GAW-1:0]    grid_rd_addr;
  logic [CELL_W-1:0] grid_rd_data;
  logic              grid_wr_en;
  logic [GAW-1:0]    grid_wr_addr;
  logic [CELL_W-1:0] grid_wr_data;
  logic              win_rd_en;
  logic [SUM_W-1:0]  win_rd_data;

  assign in_mode   = mode_t'(s_tuser);
  assign in_day    = s_tdata[2:0];
  assign in_slot   = s_tdata[7:3];
  assign in_weight = s_tdata[15:8];
  assign in_slot7  = 7'(in_slot);
  assign in_ok     = (in_day < DAY_W'(DAYS)) && (in_slot7 < 7'(SLOTS));
  assign in_addr   = {in_day, in_slot7[SB-1:0]};
  assign accept    = s_tvalid && s_tready;

  assign sweep_last = (fd == DAY_W'(DAYS - 1)) && (fs == SB'(SLOTS - 1));
  assign p1_slot7   = 7'(p1_slot);
  assign drain_done = !p1_valid && !acc_valid;
  assign exhausted  = (delivered == match_total);
  assign hit        = (state == ST_FETCH) && pend_valid && (win_rd_data == minimum);
  assign out_free   = !m_tvalid || m_tready;

  assign add_sum = {1'b0, grid_rd_data} + (CELL_W + 1)'(a_weight);
  assign add_sat = add_sum[CELL_W] ? CELL_MAX : add_sum[CELL_W-1:0];

  wsmf_grid #(
    .AW (GAW)
  ) u_grid (
    .clk     (clk),
    .rd_en   (grid_rd_en),
    .rd_addr (grid_rd_addr),
    .rd_data (grid_rd_data),
    .wr_en   (grid_wr_en),
    .wr_addr (grid_wr_addr),
    .wr_data (grid_wr_data)
  );

  wsmf_acc #(
    .WINDOW (WINDOW)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .first     (p1_slot == '0),
    .drop      (p1_slot7 >= 7'(WINDOW)),
    .emit      (p1_slot7 >= 7'(WINDOW - 1)),
    .cell_in   (grid_rd_data),
    .out_valid (acc_valid),
    .out_sum   (acc_sum)
  );

  wsmf_winmem #(
    .AW (KW)
  ) u_winmem (
    .clk     (clk),
    .rd_en   (win_rd_en),
    .rd_addr (ptr_idx),
    .rd_data (win_rd_data),
    .wr_en   (acc_valid),
    .wr_addr (k),
    .wr_data (acc_sum)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_mode)
            MODE_ADD:   state_next = ST_ADD;
            MODE_FIND:  state_next = ST_FIND;
            MODE_FETCH: state_next = exhausted ? ST_OUT : ST_FETCH;
            MODE_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_ADD:   state_next = ST_OUT;
      ST_FIND: begin
        if (sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_done) state_next = ST_OUT;
      end
      ST_FETCH: begin
        if (hit) state_next = ST_OUT;
      end
      ST_CLEAR: begin
        if (sweep_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    s_tready     = 1'b0;
    grid_rd_en   = 1'b0;
    grid_rd_addr = {fd, fs};
    grid_wr_en   = 1'b0;
    grid_wr_addr = {fd, fs};
    grid_wr_data = '0;
    win_rd_en    = 1'b0;
    case (state)
      ST_INIT, ST_CLEAR: begin
        grid_wr_en = 1'b1;
      end
      ST_IDLE: begin
        s_tready     = 1'b1;
        grid_rd_en   = s_tvalid && (in_mode == MODE_ADD);
        grid_rd_addr = in_addr;
      end
      ST_ADD: begin
        grid_wr_en   = a_ok;
        grid_wr_addr = a_addr;
        grid_wr_data = add_sat;
      end
      ST_FIND: begin
        grid_rd_en = 1'b1;
      end
      ST_FETCH: begin
        win_rd_en = 1'b1;
      end
      default: begin
        grid_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // sweep counters, reset to the first cell outside a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      fd <= '0;
      fs <= '0;
    end else if (state == ST_INIT || state == ST_CLEAR || state == ST_FIND) begin
      if (sweep_last) begin
        fd <= '0;
        fs <= '0;
      end else if (fs == SB'(SLOTS - 1)) begin
        fd <= fd + 1'b1;
        fs <= '0;
      end else begin
        fs <= fs + 1'b1;
      end
    end
  end

  // grid read tracking for the sliding sum
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_FIND);
    end
    p1_slot <= fs;
  end

  // window store, minimum and count during find
  always_ff @(posedge clk) begin
    if (accept && in_mode == MODE_FIND) begin
      k    <= '0;
      best <= SUM_MAX;
      cnt  <= '0;
    end else if (acc_valid) begin
      k <= k + 1'b1;
      if (acc_sum < best) begin
        best <= acc_sum;
        cnt  <= KW'(1);
      end else if (acc_sum == best) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // find results and fetch position
  always_ff @(posedge clk) begin
    if (rst) begin
      minimum     <= '0;
      match_total <= '0;
      delivered   <= '0;
      scan_idx    <= '0;
      scan_day    <= '0;
      scan_start  <= '0;
    end else if (state == ST_DRAIN && drain_done) begin
      minimum     <= (WIN_TOTAL == 0) ? '0 : best;
      match_total <= (WIN_TOTAL == 0) ? '0 : cnt;
      delivered   <= '0;
      scan_idx    <= '0;
      scan_day    <= '0;
      scan_start  <= '0;
    end else if (hit) begin
      delivered  <= delivered + 1'b1;
      scan_idx   <= ptr_idx;
      scan_day   <= ptr_day;
      scan_start <= ptr_start;
    end
  end

  // fetch scan pointer, one window entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b0;
    end else if (state == ST_FETCH) begin
      pend_valid <= 1'b1;
    end
    if (accept) begin
      ptr_idx   <= scan_idx;
      ptr_day   <= scan_day;
      ptr_start <= scan_start;
    end else if (state == ST_FETCH) begin
      pend_day   <= ptr_day;
      pend_start <= ptr_start;
      ptr_idx    <= ptr_idx + 1'b1;
      if (ptr_start == SB'(STARTS_M1)) begin
        ptr_start <= '0;
        ptr_day   <= ptr_day + 1'b1;
      end else begin
        ptr_start <= ptr_start + 1'b1;
      end
    end
  end

  // add operand capture
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ok     <= in_ok;
      a_addr   <= in_addr;
      a_weight <= in_weight;
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      r_valid <= 1'b0;
      r_day   <= '0;
      r_start <= '0;
      r_last  <= 1'b0;
    end else if (hit) begin
      r_valid <= 1'b1;
      r_day   <= pend_day;
      r_start <= pend_start;
      r_last  <= ((delivered + 1'b1) == match_total);
    end
  end

  assign r_start7 = 7'(r_start);
  assign r_end7   = r_valid ? (r_start7 + 7'(WINDOW - 1)) : '0;
  assign cnt_ext  = 16'(match_total);
  assign cnt_out  = (cnt_ext > 16'(CNT_MAX)) ? CNT_MAX : cnt_ext[CNT_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= {1'b0, r_end7[4:0], r_start7[4:0], r_day, cnt_out, minimum};
      m_tuser <= r_valid;
      m_tlast <= r_last;
    end
  end

endmodule

// ===== rtl/core/wsmf_grid.sv =====
module wsmf_grid
  import wsmf_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CELL_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data
);

  // slot totals, row per day, registered read
  logic [CELL_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/wsmf_winmem.sv =====
module wsmf_winmem
  import wsmf_pkg::*;
#(
  parameter int AW = 9
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [SUM_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [SUM_W-1:0] wr_data
);

  // window sums from the last find, registered read
  logic [SUM_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/wsmf_acc.sv =====
module wsmf_acc
  import wsmf_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              first,
  input  logic              drop,
  input  logic              emit,
  input  logic [CELL_W-1:0] cell_in,
  output logic              out_valid,
  output logic [SUM_W-1:0]  out_sum
);

  // running sum is wide enough for a full window without wrap
  localparam int RW = CELL_W + 2 + $clog2(WINDOW);

  logic [CELL_W-1:0] line [WINDOW];
  logic [RW-1:0]     run;
  logic [RW-1:0]     run_base;
  logic [RW-1:0]     drop_val;

  assign run_base = first ? '0 : run;
  assign drop_val = drop ? RW'(line[WINDOW-1]) : '0;

  // delay line of the last cells and sliding sum
  always_ff @(posedge clk) begin
    if (in_valid) begin
      line[0] <= cell_in;
      for (int i = 1; i < WINDOW; i++) begin
        line[i] <= line[i-1];
      end
      run <= run_base + RW'(cell_in) - drop_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid & emit;
    end
  end

  // saturate the full sum once, same as saturating term by term
  assign out_sum = (run > RW'(SUM_MAX)) ? SUM_MAX : run[SUM_W-1:0];

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import wsmf_pkg::*;

  localparam int DAYS        = 7;
  localparam int SLOTS       = 32;
  localparam int WINDOW      = 4;
  localparam int STARTS      = (SLOTS >= WINDOW) ? SLOTS - WINDOW + 1 : 0;
  localparam int WIN_TOTAL   = DAYS * STARTS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LIVE_TARGET = 500;
  localparam int TAIL_OPS    = 40;
  localparam int DRAIN_WAIT  = 300;

  // one operation on the slave side
  typedef struct packed {
    mode_t                op;
    logic [DAY_W-1:0]     day;
    logic [SLOT_W-1:0]    slot;
    logic [WEIGHT_W-1:0]  weight;
  } grid_op_t;

  // one search report on the master side
  typedef struct packed {
    logic                 hit;
    logic [SUM_W-1:0]     low_sum;
    logic [CNT_W-1:0]     hits;
    logic [DAY_W-1:0]     day;
    logic [SLOT_W-1:0]    start_slot;
    logic [SLOT_W-1:0]    end_slot;
    logic                 is_last;
  } search_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // day[2:0], slot[7:3], weight[15:8]
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // min_sum[17:0], match_count[25:18], found_day[28:26],
                               // found_start_slot[33:29], found_end_slot[38:34]
  logic [0:0]  m_tuser;        // valid_res[0]
  logic        m_tlast;        // last

  window_sum_minimum_finder #(
    .DAYS   (DAYS),
    .SLOTS  (SLOTS),
    .WINDOW (WINDOW)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow grid and search state
  logic [CELL_W-1:0] cell_total [DAYS][SLOTS];
  logic [SUM_W-1:0]  window_total [WIN_TOTAL];
  logic [SUM_W-1:0]  lowest_sum = '0;
  int unsigned       lowest_hits = 0;
  int unsigned       scan_from = 0;

  grid_op_t       grid_ops_todo [$];
  search_report_t search_reports_due [$];

  int unsigned ops_queued = 0;
  int unsigned ops_total = 0;
  int unsigned ops_accepted = 0;
  int unsigned reports_checked = 0;
  int unsigned bad_count = 0;
  int unsigned finds_run = 0;
  int unsigned windows_fetched = 0;
  int unsigned empty_fetches = 0;
  int unsigned cells_clamped = 0;
  int unsigned cycle_count = 0;
  logic        tail_phase = 1'b0;

  initial begin
    foreach (cell_total[d, s]) cell_total[d][s] = '0;
  end

  // next window at or after a position whose sum equals the minimum
  function automatic int next_lowest(input int unsigned from);
    for (int k = from; k < WIN_TOTAL; k++)
      if (window_total[k] == lowest_sum) return k;
    return -1;
  endfunction

  // advance the shadow state by one operation and queue its report
  task automatic apply_grid_op(input grid_op_t g);
    search_report_t r;
    logic [CELL_W:0] widened;
    int unsigned     acc;
    int              ix;
    int              k;
    r = '0;
    case (g.op)
      MODE_ADD: begin
        if (g.day < DAYS && g.slot < SLOTS) begin
          widened = {1'b0, cell_total[g.day][g.slot]} + g.weight;
          if (widened > CELL_MAX) begin
            cell_total[g.day][g.slot] = CELL_MAX;
            cells_clamped++;
          end else begin
            cell_total[g.day][g.slot] = widened[CELL_W-1:0];
          end
        end
      end
      MODE_FIND: begin
        lowest_sum = SUM_MAX;
        lowest_hits = 0;
        ix = 0;
        for (int d = 0; d < DAYS; d++) begin
          for (int st = 0; st < STARTS; st++) begin
            acc = 0;
            for (int w = 0; w < WINDOW; w++) begin
              acc += cell_total[d][st + w];
              if (acc > SUM_MAX) acc = SUM_MAX;
            end
            window_total[ix] = acc[SUM_W-1:0];
            ix++;
            if (acc < lowest_sum) begin
              lowest_sum = acc[SUM_W-1:0];
              lowest_hits = 1;
            end else if (acc == lowest_sum) begin
              lowest_hits++;
            end
          end
        end
        if (WIN_TOTAL == 0) begin
          lowest_sum = '0;
          lowest_hits = 0;
        end
        scan_from = 0;
        finds_run++;
      end
      MODE_FETCH: begin
        if (lowest_hits != 0) begin
          k = next_lowest(scan_from);
          if (k >= 0 && STARTS > 0) begin
            r.hit = 1'b1;
            r.day = DAY_W'(k / STARTS);
            r.start_slot = SLOT_W'(k % STARTS);
            r.end_slot = SLOT_W'(k % STARTS + WINDOW - 1);
            scan_from = k + 1;
            r.is_last = (next_lowest(scan_from) < 0);
          end
        end
        if (r.hit) windows_fetched++;
        else empty_fetches++;
      end
      default: begin
        foreach (cell_total[d, s]) cell_total[d][s] = '0;
      end
    endcase
    r.low_sum = lowest_sum;
    r.hits = (lowest_hits > CNT_MAX) ? CNT_MAX : lowest_hits[CNT_W-1:0];
    search_reports_due.insert(search_reports_due.size(), r);
  endtask

  task automatic queue_op(input mode_t op, input int d, input int s, input int w);
    grid_op_t g;
    g.op = op;
    g.day = DAY_W'(d);
    g.slot = SLOT_W'(s);
    g.weight = WEIGHT_W'(w);
    grid_ops_todo.insert(grid_ops_todo.size(), g);
    if (op != MODE_ADD || d < DAYS) ops_queued++;
  endtask

  // control operations carry junk in the unused fields
  task automatic queue_ctl(input mode_t op);
    queue_op(op, $urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 255));
  endtask

  // one add per group of four slots so every window holds exactly one of them
  task automatic lay_cover(input int lo, input int hi);
    for (int d = 0; d < DAYS; d++)
      for (int s = 3; s < SLOTS; s += 4)
        queue_op(MODE_ADD, d, s, $urandom_range(lo, hi));
  endtask

  // slave side driver
  logic     send_calm = 1'b0;
  int       send_gap = 0;
  grid_op_t on_bus = '0;

  always @(posedge clk) begin : feed_ops
    grid_op_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= MODE_ADD;
      send_gap <= 0;
    end else begin
      tail_phase <= (grid_ops_todo.size() < TAIL_OPS);
      if (s_tvalid && s_tready) begin
        apply_grid_op(on_bus);
        ops_accepted++;
        if ($urandom_range(0, 29) == 0) send_calm <= !send_calm;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (grid_ops_todo.size() != 0) begin
          nxt = grid_ops_todo.pop_front();
          on_bus <= nxt;
          s_tvalid <= 1'b1;
          s_tuser <= nxt.op;
          s_tdata <= {nxt.weight, nxt.slot, nxt.day};
          if (!send_calm && !tail_phase && $urandom_range(0, 4) == 0)
            send_gap <= $urandom_range(1, 17);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // master side monitor and checker
  logic hold_calm = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin : check_reports
    search_report_t seen;
    search_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.hit = m_tuser[0];
        seen.low_sum = m_tdata[17:0];
        seen.hits = m_tdata[25:18];
        seen.day = m_tdata[28:26];
        seen.start_slot = m_tdata[33:29];
        seen.end_slot = m_tdata[38:34];
        seen.is_last = m_tlast;
        reports_checked++;
        if (search_reports_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("report %0d arrived with none expected: valid=%0d min=%0d cnt=%0d",
                     reports_checked, seen.hit, seen.low_sum, seen.hits);
        end else begin
          want = search_reports_due.pop_front();
          if (seen !== want) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("report %0d mismatch", reports_checked);
              $display("  want valid=%0d min=%0d cnt=%0d day=%0d start=%0d end=%0d last=%0d",
                       want.hit, want.low_sum, want.hits, want.day, want.start_slot,
                       want.end_slot, want.is_last);
              $display("  got  valid=%0d min=%0d cnt=%0d day=%0d start=%0d end=%0d last=%0d",
                       seen.hit, seen.low_sum, seen.hits, seen.day, seen.start_slot,
                       seen.end_slot, seen.is_last);
            end
          end
        end
      end
      // random back-pressure bursts
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!hold_calm && !tail_phase && $urandom_range(0, 5) == 0) begin
        hold_left <= $urandom_range(0, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) hold_calm <= !hold_calm;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int  d;
    int  s;
    int  n;
    logic hammered;
    hammered = 1'b0;

    // directed: fetch before any find, out-of-range day, field extremes
    queue_ctl(MODE_FETCH);
    queue_op(MODE_ADD, 7, 5, 255);
    queue_op(MODE_ADD, 0, 0, 255);
    queue_op(MODE_ADD, 6, 31, 0);
    queue_op(MODE_ADD, 6, 31, 255);
    queue_op(MODE_ADD, 3, 16, 1);
    queue_op(MODE_ADD, 0, 31, 170);
    queue_ctl(MODE_FETCH);
    queue_ctl(MODE_FIND);
    queue_ctl(MODE_FETCH);
    queue_ctl(MODE_FETCH);
    // clear keeps the last search and the fetch position
    queue_ctl(MODE_CLEAR);
    queue_ctl(MODE_FETCH);
    queue_ctl(MODE_FIND);
    queue_ctl(MODE_FETCH);
    // a new find restarts fetching at the first window
    queue_op(MODE_ADD, 2, 1, 85);
    queue_ctl(MODE_FETCH);
    queue_ctl(MODE_FIND);
    queue_ctl(MODE_FETCH);

    // random episodes
    while (ops_queued < LIVE_TARGET) begin
      if (!hammered && ops_queued > 150) begin
        // drive one cell past its ceiling; a wrap would make its windows the minimum
        hammered = 1'b1;
        queue_ctl(MODE_CLEAR);
        lay_cover(100, 255);
        d = $urandom_range(0, DAYS - 1);
        s = 4 * $urandom_range(0, 7) + 3;
        repeat (257) queue_op(MODE_ADD, d, s, 255);
        repeat ($urandom_range(1, 3)) queue_op(MODE_ADD, d, s, $urandom_range(1, 20));
        queue_ctl(MODE_FIND);
        repeat ($urandom_range(1, 6)) queue_ctl(MODE_FETCH);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // covered grid, few minimal windows, fetch often runs dry
            queue_ctl(MODE_CLEAR);
            lay_cover(1, $urandom_range(1, 16));
            repeat ($urandom_range(0, 6))
              queue_op(MODE_ADD, $urandom_range(0, 7), $urandom_range(0, 31),
                       $urandom_range(0, 255));
            queue_ctl(MODE_FIND);
            repeat ($urandom_range(1, 40)) queue_ctl(MODE_FETCH);
          end
          5, 6: begin
            // sparse adds, sometimes with a rescan in the middle of fetching
            repeat ($urandom_range(1, 8))
              queue_op(MODE_ADD, $urandom_range(0, 7), $urandom_range(0, 31),
                       $urandom_range(0, 255));
            queue_ctl(MODE_FIND);
            repeat ($urandom_range(1, 6)) queue_ctl(MODE_FETCH);
            if ($urandom_range(0, 1) == 1) begin
              queue_ctl(MODE_FIND);
              repeat ($urandom_range(1, 3)) queue_ctl(MODE_FETCH);
            end
          end
          default: begin
            // noise: any operation with any fields
            n = $urandom_range(4, 12);
            repeat (n) begin
              case ($urandom_range(0, 7))
                0, 1, 2, 3: queue_op(MODE_ADD, $urandom_range(0, 7), $urandom_range(0, 31),
                                     $urandom_range(0, 255));
                4, 5: queue_ctl(MODE_FETCH);
                6: queue_ctl(MODE_FIND);
                default: queue_ctl(MODE_CLEAR);
              endcase
            end
          end
        endcase
      end
    end
    ops_total = grid_ops_todo.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (ops_accepted != ops_total) @(posedge clk);
    while (search_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (search_reports_due.size() != 0) begin
      bad_count++;
      $display("%0d reports never arrived", search_reports_due.size());
    end
    $display("ran %0d operations, checked %0d reports, %0d mismatches",
             ops_total, reports_checked, bad_count);
    $display("%0d finds, %0d windows fetched, %0d empty fetches, %0d clamped cell adds",
             finds_run, windows_fetched, empty_fetches, cells_clamped);
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wsmf_pkg.sv
rtl/core/wsmf_grid.sv
rtl/core/wsmf_winmem.sv
rtl/core/wsmf_acc.sv
rtl/core/window_sum_minimum_finder.sv
verif/tb_top.sv
